>>> rtl/xoshiro256pp_random_generator_core_defines.svh
// Assertion macros used by the checker file xrg_checker.sv.
`ifndef XOSHIRO256PP_RANDOM_GENERATOR_CORE_DEFINES_SVH
`define XOSHIRO256PP_RANDOM_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define XRG_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define XRG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/xrg_pkg.sv
package xrg_pkg;

   localparam logic [63:0] DefaultSeed = 64'h853c49e6748fea9b;
   localparam logic [63:0] MixA        = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MixB        = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MixC        = 64'h94d049bb133111eb;

   localparam int MixCount = 3;
   localparam logic [63:0] MixFactor [MixCount] = '{MixA, MixB, MixC};

   localparam logic [63:0] ResetWord0 = DefaultSeed;
   localparam logic [63:0] ResetWord1 = DefaultSeed * MixA;
   localparam logic [63:0] ResetWord2 = DefaultSeed * MixB;
   localparam logic [63:0] ResetWord3 = DefaultSeed * MixC;

   localparam int FracBits       = 24;
   localparam int FifoDepth      = 4;
   localparam int FifoAddrWidth  = 2;
   localparam int FifoCountWidth = 3;

   typedef enum logic {
      OpDraw   = 1'b0,
      OpReseed = 1'b1
   } opcode_type;

   typedef struct packed {
      logic               valid;
      logic [63:0]        raw;
      logic signed [31:0] low;
      logic signed [32:0] span;
   } draw_type;

   typedef struct packed {
      logic [63:0]         raw_value;
      logic [FracBits-1:0] unit_fraction;
      logic signed [31:0]  scaled_value;
   } result_type;

endpackage

>>> rtl/xrg_seed_mul.sv
module xrg_seed_mul (
   input  logic        clock,
   input  logic        load,
   input  logic [63:0] seed,
   output logic [63:0] word [xrg_pkg::MixCount]
);

   logic [63:0] low_prod_in  [xrg_pkg::MixCount];
   logic [31:0] cross_a_in   [xrg_pkg::MixCount];
   logic [31:0] cross_b_in   [xrg_pkg::MixCount];
   logic [63:0] low_prod_ff  [xrg_pkg::MixCount];
   logic [31:0] cross_a_ff   [xrg_pkg::MixCount];
   logic [31:0] cross_b_ff   [xrg_pkg::MixCount];

   // 64x64 modulo 2^64 split into one full 32x32 product and two low halves
   always_comb begin
      for (int i = 0; i < xrg_pkg::MixCount; i++) begin
         low_prod_in[i] = 64'(seed[31:0]) * 64'(xrg_pkg::MixFactor[i][31:0]);
         cross_a_in[i]  = seed[63:32] * xrg_pkg::MixFactor[i][31:0];
         cross_b_in[i]  = seed[31:0] * xrg_pkg::MixFactor[i][63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         low_prod_ff <= low_prod_in;
         cross_a_ff  <= cross_a_in;
         cross_b_ff  <= cross_b_in;
      end
   end

   always_comb begin
      for (int i = 0; i < xrg_pkg::MixCount; i++) begin
         word[i] = low_prod_ff[i] + {32'(cross_a_ff[i] + cross_b_ff[i]), 32'b0};
      end
   end

endmodule

>>> rtl/xrg_scale.sv
module xrg_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  xrg_pkg::draw_type    draw,
   output logic                 push,
   output xrg_pkg::result_type  result
);

   localparam int ProdWidth = xrg_pkg::FracBits + 1 + 33;

   logic signed [ProdWidth-1:0] prod_in;
   logic signed [ProdWidth-1:0] prod_ff;
   logic                        valid_ff;
   logic [63:0]                 raw_ff;
   logic signed [31:0]          low_ff;

   assign prod_in = $signed({1'b0, draw.raw[63 -: xrg_pkg::FracBits]}) * draw.span;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= draw.valid;
      end
      prod_ff <= prod_in;
      raw_ff  <= draw.raw;
      low_ff  <= draw.low;
   end

   // floor shift: low 32 bits of prod >>> FracBits
   assign push                 = valid_ff;
   assign result.raw_value     = raw_ff;
   assign result.unit_fraction = raw_ff[63 -: xrg_pkg::FracBits];
   assign result.scaled_value  = low_ff + $signed(prod_ff[xrg_pkg::FracBits +: 32]);

endmodule

>>> rtl/xrg_fifo.sv
module xrg_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  xrg_pkg::result_type push_data,
   input  logic                pop,
   output logic                not_empty,
   output xrg_pkg::result_type pop_data
);

   xrg_pkg::result_type                     mem [xrg_pkg::FifoDepth];
   logic [xrg_pkg::FifoAddrWidth-1:0]       wr_ptr_ff;
   logic [xrg_pkg::FifoAddrWidth-1:0]       rd_ptr_ff;
   logic [xrg_pkg::FifoCountWidth-1:0]      count_ff;
   logic [xrg_pkg::FifoCountWidth-1:0]      count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

endmodule

>>> rtl/xoshiro256pp_random_generator_core.sv
// Draw: an accepted item passes the state step, scale multiply and result queue registers
// before its first possible rsp handshake; one draw per cycle sustained while queue credit lasts.
// Reseed: req_ready drops the cycle after it is accepted while the seed products settle.
// Results wait in a 4-item queue; req_ready is held by queue credit, not by rsp_ready.
// Reset (synchronous): state loads the expanded default seed, pipeline and queue empty.
module xoshiro256pp_random_generator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [63:0]        req_seed,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_raw_value,
   output logic [23:0]        rsp_unit_fraction,
   output logic signed [31:0] rsp_scaled_value
);

   logic [63:0]                        state_ff [4];
   logic [63:0]                        state_in [4];
   logic [63:0]                        mix_word [xrg_pkg::MixCount];
   logic [63:0]                        seed_ff;
   logic                               reseed_pend_ff;
   logic [xrg_pkg::FifoCountWidth-1:0] occ_ff;
   logic [xrg_pkg::FifoCountWidth-1:0] occ_in;
   logic                               accept;
   logic                               draw_acc;
   logic                               reseed_acc;
   logic                               rsp_acc;
   logic [63:0]                        sum03;
   logic [63:0]                        raw_in;
   logic [63:0]                        t2;
   logic [63:0]                        t3;
   xrg_pkg::draw_type                  draw_in;
   xrg_pkg::draw_type                  draw_ff;
   logic                               push;
   xrg_pkg::result_type                push_data;
   xrg_pkg::result_type                pop_data;

   assign req_ready  = !reseed_pend_ff && (occ_ff < 3'(xrg_pkg::FifoDepth));
   assign accept     = req_valid && req_ready;
   assign draw_acc   = accept && (req_opcode == xrg_pkg::OpDraw);
   assign reseed_acc = accept && (req_opcode == xrg_pkg::OpReseed);
   assign rsp_acc    = rsp_valid && rsp_ready;

   // xoshiro256++ output and state step
   always_comb begin
      sum03  = state_ff[0] + state_ff[3];
      raw_in = {sum03[40:0], sum03[63:41]} + state_ff[0];
      t2     = state_ff[2] ^ state_ff[0];
      t3     = state_ff[3] ^ state_ff[1];
      state_in[1] = state_ff[1] ^ t2;
      state_in[0] = state_ff[0] ^ t3;
      state_in[2] = t2 ^ {state_ff[1][46:0], 17'b0};
      state_in[3] = {t3[18:0], t3[63:19]};
   end

   always_comb begin
      draw_in.valid = draw_acc;
      draw_in.raw   = raw_in;
      draw_in.low   = req_range_low;
      draw_in.span  = {req_range_high[31], req_range_high}
                    - {req_range_low[31], req_range_low};
   end

   always_comb begin
      occ_in = occ_ff;
      if (draw_acc && !rsp_acc) begin
         occ_in = occ_ff + 1'b1;
      end else if (rsp_acc && !draw_acc) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff[0]    <= xrg_pkg::ResetWord0;
         state_ff[1]    <= xrg_pkg::ResetWord1;
         state_ff[2]    <= xrg_pkg::ResetWord2;
         state_ff[3]    <= xrg_pkg::ResetWord3;
         reseed_pend_ff <= 1'b0;
         occ_ff         <= '0;
         draw_ff.valid  <= 1'b0;
      end else begin
         reseed_pend_ff <= reseed_acc;
         occ_ff         <= occ_in;
         draw_ff.valid  <= draw_in.valid;
         if (reseed_pend_ff) begin
            state_ff[0] <= seed_ff;
            state_ff[1] <= mix_word[0];
            state_ff[2] <= mix_word[1];
            state_ff[3] <= mix_word[2];
         end else if (draw_acc) begin
            state_ff <= state_in;
         end
      end
      if (reseed_acc) begin
         seed_ff <= req_seed;
      end
      draw_ff.raw  <= draw_in.raw;
      draw_ff.low  <= draw_in.low;
      draw_ff.span <= draw_in.span;
   end

   xrg_seed_mul u_seed_mul (
      .clock (clock),
      .load  (reseed_acc),
      .seed  (req_seed),
      .word  (mix_word)
   );

   xrg_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .draw   (draw_ff),
      .push   (push),
      .result (push_data)
   );

   xrg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_acc),
      .not_empty (rsp_valid),
      .pop_data  (pop_data)
   );

   assign rsp_raw_value     = pop_data.raw_value;
   assign rsp_unit_fraction = pop_data.unit_fraction;
   assign rsp_scaled_value  = pop_data.scaled_value;

endmodule

>>> rtl/xrg_checker.sv
`include "xoshiro256pp_random_generator_core_defines.svh"

module xrg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_opcode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [63:0]        rsp_raw_value,
   input logic [23:0]        rsp_unit_fraction,
   input logic signed [31:0] rsp_scaled_value
);

   `XRG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_raw_value) && $stable(rsp_scaled_value), "rsp item changed while stalled")
   `XRG_ASSERT_SAME(a_frac_top, rsp_valid, rsp_unit_fraction == rsp_raw_value[63:40], "unit_fraction is not the top of raw_value")
   `XRG_ASSERT_NEXT(a_reseed_busy, req_valid && req_ready && req_opcode == xrg_pkg::OpReseed, !req_ready, "item taken while reseed settles")
   `XRG_ASSERT_SAME(a_rsp_latency, $rose(rsp_valid), $past(req_valid && req_ready && req_opcode == xrg_pkg::OpDraw, 3), "result appeared without a draw three cycles earlier")

endmodule

bind xoshiro256pp_random_generator_core xrg_checker u_checker (.*);
